// ----- rtl/csoa_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csoa_pkg: shared types and constants of the current sense offset average unit
// Field widths, register indexes, fixed thresholds and reset values.
// ----------------------------------------------------------------------------
package csoa_pkg;

  // Converter and datapath widths
  localparam int ADC_BITS   = 12;
  localparam int VGAIN_W    = 18;
  localparam int CGAIN_W    = 20;
  localparam int MV_W       = 13;
  localparam int CUR_W      = 18;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  // Fixed thresholds and limits
  localparam int MV_MAX       = 8191;
  localparam int FLOOR_MV     = 500;
  localparam int OFFSET_RESET = 2800;
  localparam int CUR_MAX      = 131071;
  localparam int CUR_MIN      = -131072;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_VOLTAGE_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_GAIN = 1'b1;
  localparam logic [VGAIN_W-1:0]   VGAIN_RESET      = 18'd52813;
  localparam logic [CGAIN_W-1:0]   CGAIN_RESET      = 20'd354253;

  // Input transaction
  typedef struct packed {
    logic                kind;
    logic [ADC_BITS-1:0] adc_code;
  } in_t;

  // Result transaction
  typedef struct packed {
    logic signed [CUR_W-1:0] current_ma;
    logic                    below_floor;
    logic                    calibration_done;
  } out_t;

  // Classified sample passed from front to back
  typedef struct packed {
    logic            cal;
    logic            floor_hit;
    logic [MV_W-1:0] mv;
  } task_t;

endpackage
`default_nettype wire

// ----- rtl/csoa_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csoa_front: sample intake and classification
// Scales each ADC code to millivolts, saturates, tags calibration and floor.
// ----------------------------------------------------------------------------
module csoa_front import csoa_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [VGAIN_W-1:0] voltage_gain,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire in_t                in_data,
  output logic                    push_valid,
  input  wire logic               push_ready,
  output task_t                   push_data
);

  localparam int PROD_W = ADC_BITS + VGAIN_W;
  localparam int HI_W   = PROD_W - 16;

  logic              stage_valid_r;
  logic              stage_kind_r;
  logic [PROD_W-1:0] stage_prod_r;
  logic [HI_W-1:0]   hi;
  logic [MV_W-1:0]   mv;

  // Accept when the stage is empty or drains this cycle
  assign in_ready = !stage_valid_r || push_ready;

  // Hold the valid flag of the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else if (in_ready) begin
      stage_valid_r <= in_valid;
    end
  end

  // Register the scaling product
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_kind_r <= in_data.kind;
      stage_prod_r <= PROD_W'(in_data.adc_code) * PROD_W'(voltage_gain);
    end
  end

  // Shift, saturate and classify
  always_comb begin
    hi = stage_prod_r[PROD_W-1:16];
    if (hi > HI_W'(MV_MAX)) begin
      mv = MV_W'(MV_MAX);
    end else begin
      mv = hi[MV_W-1:0];
    end
    push_data.cal       = stage_kind_r;
    push_data.floor_hit = !stage_kind_r && (mv < MV_W'(FLOOR_MV));
    push_data.mv        = mv;
  end

  assign push_valid = stage_valid_r;

endmodule
`default_nettype wire

// ----- rtl/csoa_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csoa_queue: two-entry queue of classified samples
// Decouples intake from the arithmetic sequencer.
// ----------------------------------------------------------------------------
module csoa_queue import csoa_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push_valid,
  output logic       push_ready,
  input  wire task_t push_data,
  output logic       pop_valid,
  input  wire logic  pop_ready,
  output task_t      pop_data
);

  task_t      entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 2'd1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  // Store an entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/csoa_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// csoa_back: offset, current scaling, moving average and calibration
// Sequencer that carries out one classified sample over several steps.
// ----------------------------------------------------------------------------
module csoa_back import csoa_pkg::*; #(
  parameter int WINDOW_LEN  = 10,
  parameter int CAL_SAMPLES = 50
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [CGAIN_W-1:0] current_gain,
  input  wire logic               pop_valid,
  output logic                    pop_ready,
  input  wire task_t              pop_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output out_t                    out_data
);

  localparam int POS_W   = $clog2(WINDOW_LEN);
  localparam int TOT_W   = CUR_W + $clog2(WINDOW_LEN);
  localparam int WIN_K   = TOT_W + $clog2(WINDOW_LEN);
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  localparam int CT_W    = MV_W + CNT_W;
  localparam int CAL_K   = CT_W + $clog2(CAL_SAMPLES);
  localparam int DIFF_W  = MV_W + 1;
  localparam int CPROD_W = DIFF_W + CGAIN_W + 1;
  localparam int WPROD_W = 2 * TOT_W + 1;
  localparam int CALP_W  = 2 * CT_W + 1;

  // Reciprocals rounded up: exact quotient for every dividend of the width
  localparam logic [TOT_W:0] WIN_M =
    (TOT_W + 1)'(((64'd1 << WIN_K) + WINDOW_LEN - 1) / WINDOW_LEN);
  localparam logic [CT_W:0] CAL_M =
    (CT_W + 1)'(((64'd1 << CAL_K) + CAL_SAMPLES - 1) / CAL_SAMPLES);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_MUL   = 9'b000000010,
    ST_ACC   = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_AVG   = 9'b000010000,
    ST_CAL   = 9'b000100000,
    ST_CDIV  = 9'b001000000,
    ST_CLOAD = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

  // Control and filter state
  state_t                    state_r, state_nxt;
  logic [WINDOW_LEN-1:0]     valid_r, valid_nxt;
  logic [POS_W-1:0]          pos_r, pos_nxt;
  logic signed [TOT_W-1:0]   total_r, total_nxt;
  logic signed [CUR_W-1:0]   last_avg_r, last_avg_nxt;
  logic [MV_W-1:0]           offset_r, offset_nxt;
  logic [CT_W-1:0]           ctotal_r, ctotal_nxt;
  logic [CNT_W-1:0]          ccount_r, ccount_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Payload registers
  task_t                     task_r, task_nxt;
  logic signed [CPROD_W-1:0] cprod_r, cprod_nxt;
  logic [WPROD_W-1:0]        wprod_r, wprod_nxt;
  logic                      neg_r, neg_nxt;
  logic [CALP_W-1:0]         calp_r, calp_nxt;
  out_t                      res_r, res_nxt;
  out_t                      out_data_r, out_data_nxt;

  // Window memory
  logic signed [CUR_W-1:0]   win_mem [WINDOW_LEN];
  logic signed [CUR_W-1:0]   rd_r;

  // Datapath terms
  logic signed [DIFF_W-1:0]  diff;
  logic signed [CPROD_W-1:0] inst_wide;
  logic signed [CUR_W-1:0]   inst;
  logic signed [CUR_W-1:0]   old_val;
  logic [TOT_W-1:0]          mag;
  logic [CUR_W-1:0]          qwin;
  logic signed [CUR_W-1:0]   avg;
  logic [CT_W-1:0]           csum;
  logic                      cal_last;

  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared arithmetic terms
  always_comb begin
    diff      = $signed({1'b0, task_r.mv}) - $signed({1'b0, offset_r});
    inst_wide = cprod_r >>> 16;
    if (inst_wide > $signed(CPROD_W'(CUR_MAX))) begin
      inst = CUR_W'(CUR_MAX);
    end else if (inst_wide < $signed(CPROD_W'(CUR_MIN))) begin
      inst = CUR_W'(CUR_MIN);
    end else begin
      inst = inst_wide[CUR_W-1:0];
    end
    old_val  = valid_r[pos_r] ? rd_r : '0;
    mag      = total_r[TOT_W-1] ? unsigned'(-total_r) : unsigned'(total_r);
    qwin     = wprod_r[WIN_K +: CUR_W];
    avg      = neg_r ? -$signed(qwin) : $signed(qwin);
    csum     = ctotal_r + CT_W'(task_r.mv);
    cal_last = (ccount_r == CNT_W'(CAL_SAMPLES - 1));
  end

  // Sequence one sample
  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    pos_nxt       = pos_r;
    total_nxt     = total_r;
    last_avg_nxt  = last_avg_r;
    offset_nxt    = offset_r;
    ctotal_nxt    = ctotal_r;
    ccount_nxt    = ccount_r;
    out_valid_nxt = out_valid_r;
    task_nxt      = task_r;
    cprod_nxt     = cprod_r;
    wprod_nxt     = wprod_r;
    neg_nxt       = neg_r;
    calp_nxt      = calp_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;

    // Drop the result once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          task_nxt = pop_data;
          if (pop_data.cal) begin
            state_nxt = ST_CAL;
          end else if (pop_data.floor_hit) begin
            res_nxt.current_ma       = '0;
            res_nxt.below_floor      = 1'b1;
            res_nxt.calibration_done = 1'b0;
            state_nxt                = ST_OUT;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cprod_nxt = diff * $signed({1'b0, current_gain});
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        valid_nxt[pos_r] = 1'b1;
        total_nxt        = total_r - TOT_W'(old_val) + TOT_W'(inst);
        if (pos_r == POS_W'(WINDOW_LEN - 1)) begin
          pos_nxt = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        neg_nxt   = total_r[TOT_W-1];
        wprod_nxt = mag * WIN_M;
        state_nxt = ST_AVG;
      end
      ST_AVG: begin
        last_avg_nxt             = avg;
        res_nxt.current_ma       = avg;
        res_nxt.below_floor      = 1'b0;
        res_nxt.calibration_done = 1'b0;
        state_nxt                = ST_OUT;
      end
      ST_CAL: begin
        ctotal_nxt = csum;
        if (cal_last) begin
          state_nxt = ST_CDIV;
        end else begin
          ccount_nxt               = ccount_r + CNT_W'(1);
          res_nxt.current_ma       = last_avg_r;
          res_nxt.below_floor      = 1'b0;
          res_nxt.calibration_done = 1'b0;
          state_nxt                = ST_OUT;
        end
      end
      ST_CDIV: begin
        calp_nxt  = ctotal_r * CAL_M;
        state_nxt = ST_CLOAD;
      end
      ST_CLOAD: begin
        offset_nxt               = calp_r[CAL_K +: MV_W];
        ctotal_nxt               = '0;
        ccount_nxt               = '0;
        res_nxt.current_ma       = last_avg_r;
        res_nxt.below_floor      = 1'b0;
        res_nxt.calibration_done = 1'b1;
        state_nxt                = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      pos_r       <= '0;
      total_r     <= '0;
      last_avg_r  <= '0;
      offset_r    <= MV_W'(OFFSET_RESET);
      ctotal_r    <= '0;
      ccount_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      pos_r       <= pos_nxt;
      total_r     <= total_nxt;
      last_avg_r  <= last_avg_nxt;
      offset_r    <= offset_nxt;
      ctotal_r    <= ctotal_nxt;
      ccount_r    <= ccount_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    task_r     <= task_nxt;
    cprod_r    <= cprod_nxt;
    wprod_r    <= wprod_nxt;
    neg_r      <= neg_nxt;
    calp_r     <= calp_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // Window memory: read the outgoing entry, then overwrite it
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      rd_r <= win_mem[pos_r];
    end
    if (state_r == ST_ACC) begin
      win_mem[pos_r] <= inst;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/current_sense_offset_average_unit.sv -----
`default_nettype none
// The back steps a measure sample through current multiply, window update,
// mean multiply, mean and output load, and takes the next sample only after
// that load. Below-floor samples go straight to output load; calibration
// samples pass the calibration step, plus offset multiply and load at run end.
// Reset (synchronous, rst_n low) clears the window, sums and queue, loads the
// default gains and an offset of 2800 mV.
// ----------------------------------------------------------------------------
// current_sense_offset_average_unit: Hall current sensor offset and averaging
// Front scales ADC codes, a queue decouples it from the averaging back end.
// ----------------------------------------------------------------------------
module current_sense_offset_average_unit import csoa_pkg::*; #(
  parameter int WINDOW_LEN  = 10,
  parameter int CAL_SAMPLES = 50
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_t                   in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_t                       out_data
);

  logic [VGAIN_W-1:0] vgain_r;
  logic [CGAIN_W-1:0] cgain_r;

  logic  push_valid;
  logic  push_ready;
  task_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  task_t pop_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vgain_r <= VGAIN_RESET;
      cgain_r <= CGAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_VOLTAGE_GAIN: vgain_r <= cfg_wdata[VGAIN_W-1:0];
        REG_CURRENT_GAIN: cgain_r <= cfg_wdata[CGAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  csoa_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .voltage_gain (vgain_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_data    (push_data)
  );

  csoa_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  csoa_back #(
    .WINDOW_LEN  (WINDOW_LEN),
    .CAL_SAMPLES (CAL_SAMPLES)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .current_gain (cgain_r),
    .pop_valid    (pop_valid),
    .pop_ready    (pop_ready),
    .pop_data     (pop_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: current sense offset average unit
// Drives measure and calibration samples through the valid/ready input,
// predicts every filtered current reading in a cycle-free software model of
// the scaling, offset, window mean and offset calibration, and compares each
// result transaction field by field. Gains are changed between phases while
// the unit is idle, and both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module testbench import csoa_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                 AVG_DEPTH   = 10;
  localparam int                 CAL_COUNT   = 50;
  localparam int                 ADC_MAX     = (1 << ADC_BITS) - 1;
  localparam logic [VGAIN_W-1:0] VG_TOP      = '1;
  localparam logic [CGAIN_W-1:0] CG_TOP      = '1;
  localparam int                 CYCLE_LIMIT = 600000;
  localparam int                 DRAIN_WAIT  = 20;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_ready;
  in_t                   in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_t                  out_data;

  // Predicted unit state
  logic [VGAIN_W-1:0]      gain_mv;
  logic [CGAIN_W-1:0]      gain_ma;
  logic signed [CUR_W-1:0] avg_window [AVG_DEPTH];
  int                      window_slot;
  longint                  window_sum;
  logic [MV_W-1:0]         zero_point_mv;
  int                      zero_sum;
  int                      zero_count;
  logic signed [CUR_W-1:0] last_mean;

  out_t pending_readings [$];

  // Run bookkeeping
  int          send_idle_pct;
  int          recv_idle_pct;
  int          stall_cycles;
  int          mismatches;
  int          samples_sent;
  int          readings_checked;
  int          floors_seen;
  int          offsets_loaded;
  int unsigned cycle_count;

  current_sense_offset_average_unit #(
    .WINDOW_LEN (AVG_DEPTH),
    .CAL_SAMPLES(CAL_COUNT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // Count cycles for the run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
             pending_readings.size());
    $display("TEST FAILED");
    $finish;
  end

  // Drive result ready: long hold-off when requested, else random idling
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      out_ready    <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Check each result transaction against the oldest prediction
  always @(posedge clk) begin
    out_t want;
    out_t got;
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (pending_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected reading: current %0d floor %0b done %0b",
                   got.current_ma, got.below_floor, got.calibration_done);
      end else begin
        want = pending_readings.pop_front();
        readings_checked++;
        if (got.below_floor === 1'b1) floors_seen++;
        if (got.calibration_done === 1'b1) offsets_loaded++;
        if (got.current_ma !== want.current_ma || got.below_floor !== want.below_floor ||
            got.calibration_done !== want.calibration_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("reading %0d mismatch: expected current %0d floor %0b done %0b,",
                     readings_checked, want.current_ma, want.below_floor,
                     want.calibration_done,
                     " got current %0d floor %0b done %0b",
                     got.current_ma, got.below_floor, got.calibration_done);
        end
      end
    end
  end

  // Load reset state into the prediction
  task automatic reset_prediction();
    gain_mv       = VGAIN_RESET;
    gain_ma       = CGAIN_RESET;
    window_slot   = 0;
    window_sum    = 0;
    zero_point_mv = MV_W'(OFFSET_RESET);
    zero_sum      = 0;
    zero_count    = 0;
    last_mean     = '0;
    foreach (avg_window[i]) avg_window[i] = '0;
  endtask

  // Advance the prediction by one sample and return the expected reading
  function automatic out_t predict_filtered_current(input in_t sample);
    out_t   res;
    longint mv;
    longint amps;
    mv = (longint'(sample.adc_code) * longint'(gain_mv)) >>> 16;
    if (mv > MV_MAX) mv = MV_MAX;
    res.current_ma       = last_mean;
    res.below_floor      = 1'b0;
    res.calibration_done = 1'b0;
    if (sample.kind) begin
      // accumulate the zero-current reading, load the mean when complete
      zero_sum += int'(mv);
      zero_count++;
      if (zero_count >= CAL_COUNT) begin
        zero_point_mv        = MV_W'(zero_sum / CAL_COUNT);
        zero_sum             = 0;
        zero_count           = 0;
        res.calibration_done = 1'b1;
      end
    end else if (mv < FLOOR_MV) begin
      res.below_floor = 1'b1;
      res.current_ma  = '0;
    end else begin
      // floor-rounded current, saturated, then pushed into the window
      amps = ((mv - longint'(zero_point_mv)) * longint'(gain_ma)) >>> 16;
      if (amps > CUR_MAX) amps = CUR_MAX;
      if (amps < CUR_MIN) amps = CUR_MIN;
      window_sum -= longint'(avg_window[window_slot]);
      avg_window[window_slot] = CUR_W'(amps);
      window_sum += amps;
      window_slot = (window_slot + 1) % AVG_DEPTH;
      last_mean = CUR_W'(window_sum / AVG_DEPTH);
      res.current_ma = last_mean;
    end
    return res;
  endfunction

  // Offer one sample and hold it until the transaction completes
  task automatic send_sample(input logic kind, input int code);
    in_t item;
    int  gap;
    item.kind     = kind;
    item.adc_code = code[ADC_BITS-1:0];
    gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_ready !== 1'b1);
    pending_readings.push_back(predict_filtered_current(item));
    samples_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted reading has arrived
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_readings.size() != 0) @(negedge clk);
  endtask

  // Write one gain register once the unit is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_VOLTAGE_GAIN) gain_mv = value[VGAIN_W-1:0];
    else if (idx == REG_CURRENT_GAIN) gain_ma = value[CGAIN_W-1:0];
    @(negedge clk);
  endtask

  // Write both gains, the voltage gain with random bits above its register width
  task automatic set_gains(input logic [VGAIN_W-1:0] vg, input logic [CGAIN_W-1:0] cg);
    logic [CFG_DATA_W-1:0] word;
    word = CFG_DATA_W'($urandom);
    word[VGAIN_W-1:0] = vg;
    write_reg(REG_VOLTAGE_GAIN, word);
    write_reg(REG_CURRENT_GAIN, cg);
  endtask

  function automatic int pick_measure_code();
    int sel;
    sel = $urandom_range(99);
    if (sel < 55) return $urandom_range(0, ADC_MAX);
    if (sel < 70) return $urandom_range(100, 800);
    if (sel < 80) return ($urandom_range(1) != 0) ? ADC_MAX : 0;
    if (sel < 88) return 1 << $urandom_range(0, ADC_BITS - 1);
    return $urandom_range(2800, ADC_MAX);
  endfunction

  // Run one full calibration clustered around a code, with measures mixed in
  task automatic calibrate_near(input int center, input int spread, input int mix_pct);
    int code;
    while (zero_count != 0) send_sample(1'b1, center);
    repeat (CAL_COUNT) begin
      if ($urandom_range(99) < mix_pct) send_sample(1'b0, pick_measure_code());
      code = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (code < 0) code = 0;
      if (code > ADC_MAX) code = ADC_MAX;
      send_sample(1'b1, code);
    end
  endtask

  task automatic measure_burst(input int lo, input int hi, input int count);
    repeat (count) send_sample(1'b0, $urandom_range(lo, hi));
  endtask

  // Mostly measures, with clustered calibration samples and some noise
  task automatic random_block(input int count);
    int center;
    int code;
    center = $urandom_range(0, ADC_MAX);
    repeat (count) begin
      if ($urandom_range(99) < 30) begin
        if ($urandom_range(99) < 75)
          code = center + int'($urandom_range(0, 128)) - 64;
        else
          code = $urandom_range(0, ADC_MAX);
        if (code < 0) code = 0;
        if (code > ADC_MAX) code = ADC_MAX;
        send_sample(1'b1, code);
      end else begin
        send_sample(1'b0, pick_measure_code());
      end
    end
  endtask

  task automatic random_phase(input int send_pct, input int recv_pct,
                              input logic [VGAIN_W-1:0] vg,
                              input logic [CGAIN_W-1:0] cg, input int count);
    set_gains(vg, cg);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    random_block(count);
  endtask

  // Field extremes, floor edge, overflow, calibration pass-through, gain masking
  task automatic test_directed_cases();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(1'b0, 0);
    send_sample(1'b0, 620);
    send_sample(1'b0, 621);
    send_sample(1'b0, 3474);
    send_sample(1'b0, ADC_MAX);
    send_sample(1'b1, 0);
    send_sample(1'b1, ADC_MAX);
    send_sample(1'b0, 'h555);
    send_sample(1'b0, 'hAAA);
    write_reg(REG_VOLTAGE_GAIN, '1);
    write_reg(REG_CURRENT_GAIN, '1);
    send_sample(1'b0, ADC_MAX);
    send_sample(1'b0, 124);
    send_sample(1'b0, 125);
    send_sample(1'b0, 1000);
    write_reg(REG_VOLTAGE_GAIN, '0);
    send_sample(1'b0, ADC_MAX);
    send_sample(1'b1, 2000);
    set_gains(VGAIN_RESET, '0);
    send_sample(1'b0, ADC_MAX);
    send_sample(1'b0, 621);
    set_gains(VGAIN_RESET, CGAIN_RESET);
  endtask

  // Complete calibrations at nominal, largest, zero and random offsets
  task automatic test_calibration_sequences();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    calibrate_near(3474, 8, 25);
    measure_burst(0, ADC_MAX, 12);
    set_gains(VG_TOP, CG_TOP);
    calibrate_near(ADC_MAX, 0, 0);
    measure_burst(120, 200, 12);
    calibrate_near(0, 0, 10);
    measure_burst(ADC_MAX, ADC_MAX, 12);
    set_gains(VGAIN_RESET, CGAIN_RESET);
    calibrate_near($urandom_range(0, ADC_MAX), 200, 20);
    measure_burst(0, ADC_MAX, 12);
  endtask

  // Hold the result side off long enough for the input to stall
  task automatic test_output_backpressure();
    drain();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles  = 400;
    repeat (60) send_sample(1'b0, pick_measure_code());
  endtask

  task automatic test_random_traffic();
    random_phase(19, 48, VGAIN_RESET, CGAIN_RESET, 250);
    random_phase(19, 48, VGAIN_W'($urandom_range(25000, 110000)),
                 CGAIN_W'($urandom_range(0, CG_TOP)), 250);
    random_phase(48, 19, VG_TOP, CG_TOP, 250);
    random_phase(48, 19, VGAIN_W'($urandom_range(0, VG_TOP)),
                 CGAIN_W'($urandom_range(0, CG_TOP)), 250);
    random_phase(0, 0, VGAIN_W'($urandom_range(25000, 110000)),
                 CGAIN_W'($urandom_range(0, CG_TOP)), 250);
    random_phase(0, 0, VGAIN_W'($urandom_range(8000, 30000)),
                 CGAIN_W'($urandom_range(0, CG_TOP)), 250);
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_ready     = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_cycles  = 0;
    cycle_count   = 0;
    reset_prediction();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_cases();
    test_calibration_sequences();
    test_output_backpressure();
    test_random_traffic();

    // Let the last readings arrive, then allow for the pipeline latency
    drain();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (pending_readings.size() != 0) begin
      mismatches += pending_readings.size();
      $display("%0d predicted readings never arrived", pending_readings.size());
    end
    $display("covered %0d samples, %0d readings checked, %0d below floor, %0d offsets loaded",
             samples_sent, readings_checked, floors_seen, offsets_loaded);
    $display("gain extremes, output hold-off and three idling mixes exercised, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/csoa_pkg.sv
rtl/csoa_front.sv
rtl/csoa_queue.sv
rtl/csoa_back.sv
rtl/current_sense_offset_average_unit.sv
tb/testbench.sv
